// ----- src/dsfe_pkg.sv -----
// shared types, constants and helper functions of the drive/steer frame encoder
package dsfe_pkg;

   // sizing defaults
   localparam int AGE_BITS_DEFAULT    = 16;
   localparam int QUEUE_DEPTH_DEFAULT = 2;

   // configuration port
   localparam int CFG_W       = 16;
   localparam int CSR_INDEX_W = 8;
   localparam logic [CSR_INDEX_W-1:0] REG_RX_TIMEOUT    = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_RESEND_PERIOD = 8'd1;
   localparam logic [CFG_W-1:0] RX_TIMEOUT_RESET    = 16'd200;
   localparam logic [CFG_W-1:0] RESEND_PERIOD_RESET = 16'd100;

   // command mapping
   localparam int CMD_W = 8;
   localparam logic [CMD_W-1:0] NEUTRAL_CMD = 8'd127;
   localparam int unsigned NEUTRAL_DIV = 127;
   localparam int CODE_W     = 12;
   localparam int DELTA_W    = 9;
   localparam int MUL_W      = 16;
   localparam int HALF_SHIFT = 7;
   localparam int TBL_IDX_W  = 7;
   localparam int TBL_DEPTH  = 128;

   localparam logic [CODE_W-1:0] THR_MID = 12'h3B3;
   localparam logic [CODE_W-1:0] THR_MAX = 12'h440;
   localparam logic [CODE_W-1:0] THR_MIN = 12'h36D;
   localparam logic [CODE_W-1:0] STR_MID = 12'h381;
   localparam logic [CODE_W-1:0] STR_MIN = 12'h253;
   localparam logic [CODE_W-1:0] STR_MAX = 12'h505;

   // slopes: the side below neutral divides by 127, the side above by 128 (a shift)
   localparam int unsigned THR_UP_K = int'(THR_MAX) - int'(THR_MID);
   localparam int unsigned STR_DN_K = int'(STR_MID) - int'(STR_MIN);
   localparam logic [MUL_W-1:0] THR_DN_MUL = MUL_W'(int'(THR_MID) - int'(THR_MIN));
   localparam logic [MUL_W-1:0] STR_UP_MUL = MUL_W'(int'(STR_MAX) - int'(STR_MID));

   typedef logic [DELTA_W-1:0] div_tbl_type [TBL_DEPTH];

   // offset table n*k/127 for n in 0..127, built at elaboration
   function automatic div_tbl_type build_div_tbl(input int unsigned k);
      div_tbl_type t;
      for (int i = 0; i < TBL_DEPTH; i++) begin
         t[i] = DELTA_W'((i * k) / NEUTRAL_DIV);
      end
      return t;
   endfunction

   localparam div_tbl_type THR_UP_TBL = build_div_tbl(THR_UP_K);
   localparam div_tbl_type STR_DN_TBL = build_div_tbl(STR_DN_K);

   // one frame waiting to be serialized
   typedef struct packed {
      logic [CODE_W-1:0] thr_code;
      logic [CODE_W-1:0] str_code;
      logic              timed_out;
   } frame_type;

   // frame byte positions
   localparam int BYTE_IDX_W = 4;
   localparam logic [BYTE_IDX_W-1:0] BYTE_SOF     = 4'd0;
   localparam logic [BYTE_IDX_W-1:0] BYTE_STX     = 4'd1;
   localparam logic [BYTE_IDX_W-1:0] BYTE_THR_HI  = 4'd2;
   localparam logic [BYTE_IDX_W-1:0] BYTE_THR_MID = 4'd3;
   localparam logic [BYTE_IDX_W-1:0] BYTE_THR_LO  = 4'd4;
   localparam logic [BYTE_IDX_W-1:0] BYTE_STR_HI  = 4'd5;
   localparam logic [BYTE_IDX_W-1:0] BYTE_STR_MID = 4'd6;
   localparam logic [BYTE_IDX_W-1:0] BYTE_STR_LO  = 4'd7;
   localparam logic [BYTE_IDX_W-1:0] BYTE_ID_HI   = 4'd8;
   localparam logic [BYTE_IDX_W-1:0] BYTE_ID_LO   = 4'd9;
   localparam logic [BYTE_IDX_W-1:0] BYTE_ETX     = 4'd10;

   // fixed frame characters
   localparam logic [7:0] CHAR_SOF   = 8'h00;
   localparam logic [7:0] CHAR_STX   = 8'h02;
   localparam logic [7:0] CHAR_ETX   = 8'h03;
   localparam logic [7:0] CHAR_ID_HI = 8'h30;
   localparam logic [7:0] CHAR_ID_LO = 8'h31;

   // uppercase ascii hex digit
   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      if (nib < 4'd10) begin
         return 8'h30 + {4'b0, nib};
      end
      return 8'h37 + {4'b0, nib};
   endfunction

endpackage

// ----- src/dsfe_front.sv -----
// front end: takes items, keeps the age counters and maps commands to frame codes
module dsfe_front #(
   parameter int AGE_BITS = dsfe_pkg::AGE_BITS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [15:0]                      req_tdata,  // drive_value [7:0], steer_value [15:8]
   input  logic                             req_tuser,  // cmd [0]
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [dsfe_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [dsfe_pkg::CFG_W-1:0]       csr_data,
   output logic                             push_valid,
   input  logic                             push_ready,
   output dsfe_pkg::frame_type              push_frame
);

   localparam int CMP_W = (AGE_BITS > dsfe_pkg::CFG_W) ? AGE_BITS : dsfe_pkg::CFG_W;

   typedef struct packed {
      logic                        thr_lo;
      logic                        str_lo;
      logic [dsfe_pkg::CMD_W-1:0]  thr_n;
      logic [dsfe_pkg::CMD_W-1:0]  str_n;
      logic                        timed_out;
   } cls_type;

   typedef struct packed {
      logic                         thr_lo;
      logic                         str_lo;
      logic [dsfe_pkg::DELTA_W-1:0] thr_d;
      logic [dsfe_pkg::DELTA_W-1:0] str_d;
      logic                         timed_out;
   } dlt_type;

   logic [dsfe_pkg::CFG_W-1:0] rx_timeout_ff, rx_timeout_in;
   logic [dsfe_pkg::CFG_W-1:0] resend_period_ff, resend_period_in;
   logic [AGE_BITS-1:0] cmd_age_ff, cmd_age_in, cmd_age_inc;
   logic [AGE_BITS-1:0] ntr_age_ff, ntr_age_in, ntr_age_inc;
   logic s1_valid_ff, s1_valid_in, s2_valid_ff, s2_valid_in;
   cls_type s1_ff, s1_in;
   dlt_type s2_ff, s2_in;
   logic s1_ready, s2_ready, accept, frame_go, cmd_due, ntr_due, sel_to;
   logic [dsfe_pkg::CMD_W-1:0] sel_drive, sel_steer;
   logic [dsfe_pkg::MUL_W-1:0] thr_prod, str_prod;

   // pipeline flow
   assign s2_ready   = !s2_valid_ff || push_ready;
   assign s1_ready   = !s1_valid_ff || s2_ready;
   assign req_tready = s1_ready;
   assign accept     = req_tvalid && s1_ready;
   assign csr_ready  = 1'b1;

   // configuration writes
   always_comb begin
      rx_timeout_in    = rx_timeout_ff;
      resend_period_in = resend_period_ff;
      if (csr_valid) begin
         unique case (csr_index)
            dsfe_pkg::REG_RX_TIMEOUT:    rx_timeout_in    = csr_data;
            dsfe_pkg::REG_RESEND_PERIOD: resend_period_in = csr_data;
            default: ;
         endcase
      end
   end

   // saturating ages and due checks
   assign cmd_age_inc = (cmd_age_ff == '1) ? cmd_age_ff : cmd_age_ff + 1'b1;
   assign ntr_age_inc = (ntr_age_ff == '1) ? ntr_age_ff : ntr_age_ff + 1'b1;
   assign cmd_due     = CMP_W'(cmd_age_inc) >= CMP_W'(rx_timeout_ff);
   assign ntr_due     = CMP_W'(ntr_age_inc) >= CMP_W'(resend_period_ff);

   // classify the accepted item: command frame, neutral frame or silent tick
   always_comb begin
      cmd_age_in = cmd_age_ff;
      ntr_age_in = ntr_age_ff;
      frame_go   = 1'b0;
      sel_drive  = req_tdata[7:0];
      sel_steer  = req_tdata[15:8];
      sel_to     = 1'b0;
      if (accept) begin
         if (!req_tuser) begin
            cmd_age_in = '0;
            frame_go   = 1'b1;
         end else begin
            cmd_age_in = cmd_age_inc;
            ntr_age_in = ntr_age_inc;
            if (cmd_due && ntr_due) begin
               ntr_age_in = '0;
               frame_go   = 1'b1;
               sel_drive  = dsfe_pkg::NEUTRAL_CMD;
               sel_steer  = dsfe_pkg::NEUTRAL_CMD;
               sel_to     = 1'b1;
            end
         end
      end
   end

   // stage 1: side of neutral and distance from it
   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_in       = s1_ff;
      if (s1_ready) begin
         s1_valid_in     = frame_go;
         s1_in.thr_lo    = sel_drive < dsfe_pkg::NEUTRAL_CMD;
         s1_in.str_lo    = sel_steer < dsfe_pkg::NEUTRAL_CMD;
         s1_in.thr_n     = s1_in.thr_lo ? dsfe_pkg::NEUTRAL_CMD - sel_drive
                                        : sel_drive - dsfe_pkg::NEUTRAL_CMD;
         s1_in.str_n     = s1_in.str_lo ? dsfe_pkg::NEUTRAL_CMD - sel_steer
                                        : sel_steer - dsfe_pkg::NEUTRAL_CMD;
         s1_in.timed_out = sel_to;
      end
   end

   // stage 2: code offsets, table below neutral, multiply and shift above
   assign thr_prod = dsfe_pkg::MUL_W'(s1_ff.thr_n) * dsfe_pkg::THR_DN_MUL;
   assign str_prod = dsfe_pkg::MUL_W'(s1_ff.str_n) * dsfe_pkg::STR_UP_MUL;

   always_comb begin
      s2_valid_in = s2_valid_ff;
      s2_in       = s2_ff;
      if (s2_ready) begin
         s2_valid_in     = s1_valid_ff;
         s2_in.thr_lo    = s1_ff.thr_lo;
         s2_in.str_lo    = s1_ff.str_lo;
         s2_in.thr_d     = s1_ff.thr_lo
                           ? dsfe_pkg::THR_UP_TBL[s1_ff.thr_n[dsfe_pkg::TBL_IDX_W-1:0]]
                           : thr_prod[dsfe_pkg::HALF_SHIFT +: dsfe_pkg::DELTA_W];
         s2_in.str_d     = s1_ff.str_lo
                           ? dsfe_pkg::STR_DN_TBL[s1_ff.str_n[dsfe_pkg::TBL_IDX_W-1:0]]
                           : str_prod[dsfe_pkg::HALF_SHIFT +: dsfe_pkg::DELTA_W];
         s2_in.timed_out = s1_ff.timed_out;
      end
   end

   // final codes into the queue
   assign push_valid           = s2_valid_ff;
   assign push_frame.thr_code  = s2_ff.thr_lo
                                 ? dsfe_pkg::THR_MID + dsfe_pkg::CODE_W'(s2_ff.thr_d)
                                 : dsfe_pkg::THR_MID - dsfe_pkg::CODE_W'(s2_ff.thr_d);
   assign push_frame.str_code  = s2_ff.str_lo
                                 ? dsfe_pkg::STR_MID - dsfe_pkg::CODE_W'(s2_ff.str_d)
                                 : dsfe_pkg::STR_MID + dsfe_pkg::CODE_W'(s2_ff.str_d);
   assign push_frame.timed_out = s2_ff.timed_out;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rx_timeout_ff    <= dsfe_pkg::RX_TIMEOUT_RESET;
         resend_period_ff <= dsfe_pkg::RESEND_PERIOD_RESET;
         cmd_age_ff       <= '0;
         ntr_age_ff       <= '0;
         s1_valid_ff      <= 1'b0;
         s2_valid_ff      <= 1'b0;
      end else begin
         rx_timeout_ff    <= rx_timeout_in;
         resend_period_ff <= resend_period_in;
         cmd_age_ff       <= cmd_age_in;
         ntr_age_ff       <= ntr_age_in;
         s1_valid_ff      <= s1_valid_in;
         s2_valid_ff      <= s2_valid_in;
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      s1_ff <= s1_in;
      s2_ff <= s2_in;
   end

endmodule

// ----- src/dsfe_queue.sv -----
// small frame queue between the front end and the byte serializer
module dsfe_queue #(
   parameter int DEPTH = dsfe_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   output logic                push_ready,
   input  dsfe_pkg::frame_type push_frame,
   output logic                pop_valid,
   input  logic                pop_ready,
   output dsfe_pkg::frame_type pop_frame
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   dsfe_pkg::frame_type mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic push, pop;

   assign push_ready = count_ff != CNT_W'(DEPTH);
   assign pop_valid  = count_ff != '0;
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_frame  = mem_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      unique case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_frame;
      end
   end

endmodule

// ----- src/dsfe_back.sv -----
// back end: turns queued frames into bytes, one per cycle while rsp_tready allows, through an output register
module dsfe_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                pop_valid,
   output logic                pop_ready,
   input  dsfe_pkg::frame_type pop_frame,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [7:0]          rsp_tdata,  // frame_byte [7:0]
   output logic                rsp_tlast,  // last_byte
   output logic                rsp_tuser   // timed_out [0]
);

   logic [dsfe_pkg::BYTE_IDX_W-1:0] idx_ff, idx_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_data_ff, rsp_data_in, cur_byte;
   logic       rsp_last_ff, rsp_last_in, rsp_user_ff, rsp_user_in;
   logic       out_free, load, at_end;

   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign load      = pop_valid && out_free;
   assign at_end    = idx_ff == dsfe_pkg::BYTE_ETX;
   assign pop_ready = load && at_end;

   // byte at the current position of the head frame
   always_comb begin
      unique case (idx_ff)
         dsfe_pkg::BYTE_SOF:     cur_byte = dsfe_pkg::CHAR_SOF;
         dsfe_pkg::BYTE_STX:     cur_byte = dsfe_pkg::CHAR_STX;
         dsfe_pkg::BYTE_THR_HI:  cur_byte = dsfe_pkg::hex_char(pop_frame.thr_code[11:8]);
         dsfe_pkg::BYTE_THR_MID: cur_byte = dsfe_pkg::hex_char(pop_frame.thr_code[7:4]);
         dsfe_pkg::BYTE_THR_LO:  cur_byte = dsfe_pkg::hex_char(pop_frame.thr_code[3:0]);
         dsfe_pkg::BYTE_STR_HI:  cur_byte = dsfe_pkg::hex_char(pop_frame.str_code[11:8]);
         dsfe_pkg::BYTE_STR_MID: cur_byte = dsfe_pkg::hex_char(pop_frame.str_code[7:4]);
         dsfe_pkg::BYTE_STR_LO:  cur_byte = dsfe_pkg::hex_char(pop_frame.str_code[3:0]);
         dsfe_pkg::BYTE_ID_HI:   cur_byte = dsfe_pkg::CHAR_ID_HI;
         dsfe_pkg::BYTE_ID_LO:   cur_byte = dsfe_pkg::CHAR_ID_LO;
         dsfe_pkg::BYTE_ETX:     cur_byte = dsfe_pkg::CHAR_ETX;
         default:                cur_byte = dsfe_pkg::CHAR_SOF;
      endcase
   end

   // output register and byte position
   always_comb begin
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_user_in  = rsp_user_ff;
      if (out_free) begin
         rsp_valid_in = pop_valid;
      end
      if (load) begin
         idx_in      = at_end ? dsfe_pkg::BYTE_SOF : idx_ff + 1'b1;
         rsp_data_in = cur_byte;
         rsp_last_in = at_end;
         rsp_user_in = pop_frame.timed_out;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= dsfe_pkg::BYTE_SOF;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

// ----- src/drive_steer_frame_encoder_failsafe.sv -----
// top level of the drive/steer frame encoder with failsafe neutral resend
//
// req channel: one item per handshake, either a drive/steer command (tuser 0) or a
// one millisecond tick (tuser 1). A command always yields an 11-byte frame; a tick
// yields a neutral frame only once timed out and the resend period has elapsed,
// otherwise it only advances the age counters.
// rsp channel: one frame byte per item, tlast on the closing 0x03, tuser is the
// timed-out flag of that frame.
// csr channel: index 0 is the command timeout, index 1 the resend period, both in
// ticks; writes are always ready and other indexes are ignored.
// An accepted item passes the two front stages and a queue write, then its first byte
// is loaded into the output register.
// The serializer sends one byte per cycle while rsp_tready is high; ticks that produce
// nothing are taken one per cycle unless the front stages are stalled.
// The frame queue lets the front keep taking items while bytes are stalled; once
// the queue and front stages are full, req_tready drops until bytes drain.
// Reset: synchronous; registers return to 200 and 100, ages to zero, queue empty.
module drive_steer_frame_encoder_failsafe #(
   parameter int AGE_BITS    = dsfe_pkg::AGE_BITS_DEFAULT,
   parameter int QUEUE_DEPTH = dsfe_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [15:0]                      req_tdata,  // drive_value [7:0], steer_value [15:8]
   input  logic                             req_tuser,  // cmd [0]
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [7:0]                       rsp_tdata,  // frame_byte [7:0]
   output logic                             rsp_tlast,  // last_byte
   output logic                             rsp_tuser,  // timed_out [0]
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [dsfe_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [dsfe_pkg::CFG_W-1:0]       csr_data
);

   logic                push_valid, push_ready, pop_valid, pop_ready;
   dsfe_pkg::frame_type push_frame, pop_frame;

   // command classification and code mapping
   dsfe_front #(
      .AGE_BITS (AGE_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_frame (push_frame)
   );

   // frames waiting for the serializer
   dsfe_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_frame (push_frame),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_frame  (pop_frame)
   );

   // byte serializer
   dsfe_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_frame  (pop_frame),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// ----- test/dsfe_tb_pkg.sv -----
// item codes shared by the encoder testbench and its frame checker
package dsfe_tb_pkg;

   // req_tuser values
   localparam logic CMD_COMMAND = 1'b0;
   localparam logic CMD_TICK    = 1'b1;

endpackage

// ----- test/dsfe_frame_checker.sv -----
// frame checker: predicts the encoder's output bytes and compares them with the rsp stream
module dsfe_frame_checker
   import dsfe_pkg::*;
   import dsfe_tb_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic [15:0]            req_tdata,   // drive_value [7:0], steer_value [15:8]
   input  logic                   req_tuser,   // cmd [0]
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic [7:0]             rsp_tdata,   // frame_byte [7:0]
   input  logic                   rsp_tlast,   // last_byte
   input  logic                   rsp_tuser,   // timed_out [0]
   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]       csr_data,
   output int unsigned            mismatches,
   output int                     outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int          MAX_REPORTS = 10;
   localparam int          FRAME_BYTES = 11;
   localparam logic [15:0] AGE_MAX     = 16'hFFFF;
   localparam logic [7:0]  ASCII_ZERO  = "0";
   localparam logic [7:0]  ASCII_UPPER = "A";

   typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic       tout;
   } frame_byte_type;

   // predicted state and registers
   logic [CFG_W-1:0] timeout_ms;
   logic [CFG_W-1:0] period_ms;
   logic [15:0]      command_age;
   logic [15:0]      neutral_age;
   logic             failsafe_on;
   frame_byte_type   bytes_due[$];

   // drive byte to throttle code, below neutral divides by 127, above by 128
   function automatic logic [CODE_W-1:0] throttle_code_of(input logic [7:0] d);
      int unsigned dv, mid, hi, lo, n;
      dv  = d;
      n   = NEUTRAL_CMD;
      mid = THR_MID;
      hi  = THR_MAX;
      lo  = THR_MIN;
      if (dv < n) begin
         return CODE_W'(mid + ((n - dv) * (hi - mid)) / 127);
      end
      if (dv > n) begin
         return CODE_W'(mid - ((dv - n) * (mid - lo)) / 128);
      end
      return CODE_W'(mid);
   endfunction

   // steer byte to steering code, mirrored slope direction
   function automatic logic [CODE_W-1:0] steer_code_of(input logic [7:0] s);
      int unsigned sv, mid, hi, lo, n;
      sv  = s;
      n   = NEUTRAL_CMD;
      mid = STR_MID;
      hi  = STR_MAX;
      lo  = STR_MIN;
      if (sv < n) begin
         return CODE_W'(mid - ((n - sv) * (mid - lo)) / 127);
      end
      if (sv > n) begin
         return CODE_W'(mid + ((sv - n) * (hi - mid)) / 128);
      end
      return CODE_W'(mid);
   endfunction

   function automatic logic [7:0] hex_digit_of(input logic [3:0] nib);
      return (nib > 4'd9) ? ASCII_UPPER + 8'(nib - 4'd10) : ASCII_ZERO + 8'(nib);
   endfunction

   function automatic logic [15:0] age_step(input logic [15:0] age);
      return (age == AGE_MAX) ? AGE_MAX : age + 16'd1;
   endfunction

   // append the eleven bytes of one frame to the expected stream
   task automatic queue_frame(input logic [7:0] d, input logic [7:0] s);
      logic [CODE_W-1:0] thr, str;
      logic [7:0]        b [FRAME_BYTES];
      thr   = throttle_code_of(d);
      str   = steer_code_of(s);
      b[0]  = CHAR_SOF;
      b[1]  = CHAR_STX;
      b[2]  = hex_digit_of(thr[11:8]);
      b[3]  = hex_digit_of(thr[7:4]);
      b[4]  = hex_digit_of(thr[3:0]);
      b[5]  = hex_digit_of(str[11:8]);
      b[6]  = hex_digit_of(str[7:4]);
      b[7]  = hex_digit_of(str[3:0]);
      b[8]  = CHAR_ID_HI;
      b[9]  = CHAR_ID_LO;
      b[10] = CHAR_ETX;
      for (int k = 0; k < FRAME_BYTES; k++) begin
         bytes_due.push_back('{data: b[k], last: (k == FRAME_BYTES - 1), tout: failsafe_on});
      end
   endtask

   always @(posedge clock) begin
      frame_byte_type want;
      if (reset) begin
         timeout_ms  = RX_TIMEOUT_RESET;
         period_ms   = RESEND_PERIOD_RESET;
         command_age = '0;
         neutral_age = '0;
         failsafe_on = 1'b0;
         mismatches  = 0;
         bytes_due.delete();
      end else begin
         // compare each accepted byte with the oldest expectation
         if (rsp_tvalid && rsp_tready) begin
            if (bytes_due.size() == 0) begin
               if (mismatches < MAX_REPORTS) begin
                  $display("%0t: unexpected byte data=%h last=%b tout=%b",
                           $realtime, rsp_tdata, rsp_tlast, rsp_tuser);
               end
               mismatches++;
            end else begin
               want = bytes_due.pop_front();
               if (rsp_tdata !== want.data || rsp_tlast !== want.last ||
                   rsp_tuser !== want.tout) begin
                  if (mismatches < MAX_REPORTS) begin
                     $display("%0t: byte mismatch exp data=%h last=%b tout=%b got data=%h last=%b tout=%b",
                              $realtime, want.data, want.last, want.tout,
                              rsp_tdata, rsp_tlast, rsp_tuser);
                  end
                  mismatches++;
               end
            end
         end

         // register writes, unknown indexes ignored
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_RX_TIMEOUT:    timeout_ms = csr_data;
               REG_RESEND_PERIOD: period_ms  = csr_data;
               default: ;
            endcase
         end

         // accepted item: command frame or tick with possible neutral resend
         if (req_tvalid && req_tready) begin
            if (req_tuser == CMD_COMMAND) begin
               command_age = '0;
               failsafe_on = 1'b0;
               queue_frame(req_tdata[7:0], req_tdata[15:8]);
            end else begin
               command_age = age_step(command_age);
               neutral_age = age_step(neutral_age);
               if (command_age >= timeout_ms) begin
                  failsafe_on = 1'b1;
                  if (neutral_age >= period_ms) begin
                     neutral_age = '0;
                     queue_frame(NEUTRAL_CMD, NEUTRAL_CMD);
                  end
               end
            end
         end
      end
      outstanding = bytes_due.size();
   end

endmodule

// ----- test/drive_steer_frame_encoder_failsafe_tb.sv -----
// testbench top: stimulus, handshake pacing and verdict for the frame encoder
module drive_steer_frame_encoder_failsafe_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import dsfe_pkg::*;
   import dsfe_tb_pkg::*;

   localparam int LIMIT_CYCLES  = 1_000_000;
   localparam int MAX_GAP       = 16;
   localparam int HOLD_CYCLES   = 300;
   localparam int SETTLE_CYCLES = 12;
   localparam int PHASE_ITEMS   = 37;
   localparam logic [CSR_INDEX_W-1:0] REG_UNMAPPED = 8'hFF;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [15:0]            req_tdata;   // drive_value [7:0], steer_value [15:8]
   logic                   req_tuser;   // cmd [0]
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [7:0]             rsp_tdata;   // frame_byte [7:0]
   logic                   rsp_tlast;   // last_byte
   logic                   rsp_tuser;   // timed_out [0]
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CFG_W-1:0]       csr_data;

   int unsigned mismatches;
   int          outstanding;
   int unsigned cycle_count   = 0;
   bit          gaps_on       = 1'b1;
   int          hold_requests = 0;

   drive_steer_frame_encoder_failsafe DUT (.*);

   dsfe_frame_checker u_checker (.*);

   always #6 clock = ~clock;

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("tb: failure");
         $finish;
      end
   end

   // byte receiver: random stalls, one long hold-off on request
   initial begin
      int stall;
      int holds_done;
      holds_done = 0;
      rsp_tready = 1'b0;
      @(negedge clock iff !reset);
      forever begin
         if (hold_requests != holds_done) begin
            stall      = HOLD_CYCLES;
            holds_done = hold_requests;
         end else begin
            stall = gaps_on ? $urandom_range(0, MAX_GAP) : 0;
         end
         @(negedge clock);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
      end
   end

   // offer one item and wait until it is taken
   task automatic offer(input logic kind, input logic [7:0] d, input logic [7:0] s);
      int gap;
      gap = gaps_on ? $urandom_range(0, MAX_GAP) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {s, d};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // stop offering and let every expected byte drain
   task automatic settle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      wait (outstanding == 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [CFG_W-1:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // command byte biased toward the ends and the neutral point
   function automatic logic [7:0] pick_cmd_value();
      case ($urandom_range(0, 7))
         0:       return 8'd0;
         1:       return 8'd255;
         2:       return NEUTRAL_CMD;
         3:       return $urandom_range(0, 1) ? NEUTRAL_CMD - 8'd1 : NEUTRAL_CMD + 8'd1;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   initial begin
      logic [7:0] dir_drive [13] = '{8'd0, 8'd255, 8'd127, 8'd126, 8'd128, 8'd1, 8'd254,
                                     8'hAA, 8'h55, 8'd127, 8'd0, 8'd255, 8'd127};
      logic [7:0] dir_steer [13] = '{8'd0, 8'd255, 8'd127, 8'd128, 8'd126, 8'd254, 8'd1,
                                     8'h55, 8'hAA, 8'd0, 8'd127, 8'd127, 8'd255};
      logic [CFG_W-1:0] timeout_val, period_val;
      logic             kind;

      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = CMD_COMMAND;
      csr_valid  = 1'b0;
      csr_index  = '0;
      csr_data   = '0;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // extremes and neutral points of both mappings at reset settings
      foreach (dir_drive[i]) offer(CMD_COMMAND, dir_drive[i], dir_steer[i]);
      // default timeout and resend period through ticks alone
      repeat (220) offer(CMD_TICK, 8'($urandom), 8'($urandom));

      // ignored index, then settings of one: resend on every tick
      settle();
      write_reg(REG_UNMAPPED, 16'd1);
      write_reg(REG_RX_TIMEOUT, 16'd1);
      write_reg(REG_RESEND_PERIOD, 16'd1);
      offer(CMD_COMMAND, 8'd127, 8'd127);
      repeat (4) offer(CMD_TICK, 8'hFF, 8'h00);
      offer(CMD_COMMAND, 8'd0, 8'd255);
      offer(CMD_TICK, 8'h00, 8'hFF);

      // random mix of commands and ticks over several settings
      for (int ph = 0; ph < 6; ph++) begin
         settle();
         timeout_val = (ph == 4) ? 16'hFFFF : 16'($urandom_range(1, 30));
         period_val  = (ph == 5) ? 16'hFFFF : 16'($urandom_range(1, 12));
         write_reg(REG_RX_TIMEOUT, timeout_val);
         write_reg(REG_RESEND_PERIOD, period_val);
         gaps_on = (ph != 2);
         repeat (PHASE_ITEMS) begin
            kind = ($urandom_range(0, 99) < 60) ? CMD_TICK : CMD_COMMAND;
            offer(kind, pick_cmd_value(), pick_cmd_value());
         end
      end

      // long receiver hold-off while commands keep coming
      settle();
      gaps_on = 1'b0;
      hold_requests++;
      repeat (12) offer(CMD_COMMAND, pick_cmd_value(), pick_cmd_value());

      // short settings again after the hold-off
      settle();
      write_reg(REG_RX_TIMEOUT, 16'd1);
      write_reg(REG_RESEND_PERIOD, 16'd2);
      gaps_on = 1'b1;
      repeat (3) offer(CMD_TICK, 8'($urandom), 8'($urandom));
      offer(CMD_COMMAND, 8'd127, 8'd127);

      settle();
      if (mismatches == 0 && outstanding == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
src/dsfe_pkg.sv
src/dsfe_front.sv
src/dsfe_queue.sv
src/dsfe_back.sv
src/drive_steer_frame_encoder_failsafe.sv
test/dsfe_tb_pkg.sv
test/dsfe_frame_checker.sv
test/drive_steer_frame_encoder_failsafe_tb.sv
